// ===== src/sjd_pkg.sv =====
package sjd_pkg;

    localparam int IDX_W = 14;
    localparam int CP_W  = 16;

    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_TABLE = 2'd2;

    localparam logic [7:0] ASCII_END   = 8'h80;
    localparam logic [7:0] BYTE_A0     = 8'hA0;
    localparam logic [7:0] KANA_END    = 8'hE0;
    localparam logic [7:0] LEAD_END    = 8'hF0;
    localparam logic [7:0] LEAD_BASE_1 = 8'h81;
    localparam logic [7:0] LEAD_BASE_2 = 8'hC1;
    localparam logic [7:0] TRAIL_MIN   = 8'h40;
    localparam logic [7:0] TRAIL_MAX   = 8'hFC;
    localparam logic [7:0] TRAIL_HOLE  = 8'h7F;
    localparam logic [7:0] TRAIL_HIGH  = 8'h9F;
    localparam logic [7:0] TRAIL_SKIP  = 8'h41;

    localparam logic [CP_W-1:0]  KANA_OFFSET   = 16'hFEC0;
    localparam logic [IDX_W-1:0] CELLS_PER_ROW = 14'd94;

    // Decision for one accepted item, from the front classifier to the pipeline
    typedef struct packed {
        logic             emit;      // item gives a result
        logic             lookup;    // result comes from the table
        logic             bad;       // result is a bad-input mark
        logic [CP_W-1:0]  code;      // direct code point when no lookup
        logic             set_lead;  // hold this byte as a pending lead
        logic             clr_lead;  // drop the pending lead
        logic             wr;        // table write in range
        logic [IDX_W-1:0] mem_idx;   // table address for read or write
    } t_front;

endpackage

// ===== src/sjd_front.sv =====
module sjd_front
    import sjd_pkg::*;
#(
    parameter int TABLE_DEPTH = 8836
) (
    input  logic [1:0]       i_cmd,
    input  logic [7:0]       i_data_byte,
    input  logic [IDX_W-1:0] i_table_index,
    input  logic             i_lead_pending,
    input  logic [7:0]       i_lead_byte,
    output t_front           o_front
);

    localparam logic [IDX_W-1:0] DEPTH_LIM = IDX_W'(TABLE_DEPTH);

    logic [5:0]       row_off;
    logic             hi_half;
    logic [6:0]       ku;
    logic [6:0]       ten;
    logic [IDX_W-1:0] pair_idx;
    logic             trail_ok;
    logic             pair_in_range;

    // Row/cell arithmetic to the linear JIS X 0208 index
    always_comb begin
        row_off = (i_lead_byte < BYTE_A0) ? 6'(i_lead_byte - LEAD_BASE_1)
                                          : 6'(i_lead_byte - LEAD_BASE_2);
        hi_half = (i_data_byte >= TRAIL_HIGH);
        ku      = {row_off, 1'b0} + 7'(hi_half);
        if (hi_half) begin
            ten = 7'(i_data_byte - TRAIL_HIGH);
        end else if (i_data_byte < TRAIL_HOLE) begin
            ten = 7'(i_data_byte - TRAIL_MIN);
        end else begin
            ten = 7'(i_data_byte - TRAIL_SKIP);
        end
        pair_idx      = IDX_W'(IDX_W'(ku) * CELLS_PER_ROW + IDX_W'(ten));
        trail_ok      = (i_data_byte >= TRAIL_MIN) && (i_data_byte <= TRAIL_MAX)
                        && (i_data_byte != TRAIL_HOLE);
        pair_in_range = (pair_idx < DEPTH_LIM);
    end

    always_comb begin
        o_front         = '0;
        o_front.mem_idx = pair_idx;
        unique case (i_cmd)
            CMD_DATA: begin
                if (i_lead_pending) begin
                    o_front.clr_lead = 1'b1;
                    o_front.emit     = 1'b1;
                    if (trail_ok && pair_in_range) begin
                        o_front.lookup = 1'b1;
                    end else begin
                        o_front.bad = 1'b1;
                    end
                end else if (i_data_byte < ASCII_END) begin
                    o_front.emit = 1'b1;
                    o_front.code = CP_W'(i_data_byte);
                end else if (i_data_byte > BYTE_A0 && i_data_byte < KANA_END) begin
                    o_front.emit = 1'b1;
                    o_front.code = KANA_OFFSET + CP_W'(i_data_byte);
                end else if (i_data_byte > ASCII_END && i_data_byte < LEAD_END
                             && i_data_byte != BYTE_A0) begin
                    o_front.set_lead = 1'b1;
                end else begin
                    o_front.emit = 1'b1;
                    o_front.bad  = 1'b1;
                end
            end
            CMD_FLUSH: begin
                if (i_lead_pending) begin
                    o_front.clr_lead = 1'b1;
                    o_front.emit     = 1'b1;
                    o_front.bad      = 1'b1;
                end
            end
            CMD_TABLE: begin
                o_front.mem_idx = i_table_index;
                o_front.wr      = (i_table_index < DEPTH_LIM);
            end
            default: begin
                o_front.emit = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/sjd_table_ram.sv =====
module sjd_table_ram
    import sjd_pkg::*;
#(
    parameter int DEPTH  = 8836,
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [CP_W-1:0]   i_wdata,
    output logic [CP_W-1:0]   o_rdata
);

    logic [CP_W-1:0] r_mem [DEPTH];
    logic [CP_W-1:0] r_rdata;

    // Single port: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/shift_jis_to_unicode_decoder_unit.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | i_cmd, i_data_byte, i_table_index, i_table_value
// output  | out       | o_valid / i_stall  | o_code_point, o_bad_input
//
// One item is taken per cycle when o_stall is low; each result is registered in the lookup stage
// and then in the result register. The rate is set by the single-port table RAM: one access
// (a read per trail byte or a write per table item) each cycle, with a registered read.
// Reset clears the pending lead and the pipeline valids; the table is not
// cleared and must be loaded by table items before data that needs it.
// A stall on the output holds the result register and the lookup stage, and
// backs up to the input only when both are full.
module shift_jis_to_unicode_decoder_unit
    import sjd_pkg::*;
#(
    parameter int TABLE_DEPTH = 8836
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_cmd,
    input  logic [7:0]       i_data_byte,
    input  logic [IDX_W-1:0] i_table_index,
    input  logic [CP_W-1:0]  i_table_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CP_W-1:0]  o_code_point,
    output logic             o_bad_input
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Pending lead byte
    logic            r_lead_pending;
    logic [7:0]      r_lead_byte;

    // Lookup stage: item waiting on the table read data
    logic            r_s1_valid;
    logic            r_s1_lookup;
    logic            r_s1_bad;
    logic [CP_W-1:0] r_s1_code;

    // Result register
    logic            r_out_valid;
    logic [CP_W-1:0] r_out_code;
    logic            r_out_bad;
    logic            n_out_bad;
    logic [CP_W-1:0] n_out_code;

    t_front          front;
    logic [CP_W-1:0] rd_data;
    logic            in_xfer;
    logic            s1_move;
    logic            ram_en;

    sjd_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_table_index  (i_table_index),
        .i_lead_pending (r_lead_pending),
        .i_lead_byte    (r_lead_byte),
        .o_front        (front)
    );

    // Advance the lookup stage when the result register is free or draining;
    // take a new transfer whenever the lookup stage will be free.
    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_move;
    assign in_xfer = i_valid && !o_stall;

    // Touch the table only on a transfer, so the read data holds while stalled
    assign ram_en = in_xfer && (front.lookup || front.wr);

    sjd_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (front.wr),
        .i_addr  (front.mem_idx[ADDR_W-1:0]),
        .i_wdata (i_table_value),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_byte    <= '0;
        end else if (in_xfer) begin
            if (front.set_lead) begin
                r_lead_pending <= 1'b1;
                r_lead_byte    <= i_data_byte;
            end else if (front.clr_lead) begin
                r_lead_pending <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= front.emit;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_lookup <= front.lookup;
            r_s1_bad    <= front.bad;
            r_s1_code   <= front.code;
        end
    end

    // An unmapped (zero) table entry turns into a bad-input mark
    always_comb begin
        n_out_bad  = r_s1_bad || (r_s1_lookup && (rd_data == '0));
        if (n_out_bad) begin
            n_out_code = '0;
        end else if (r_s1_lookup) begin
            n_out_code = rd_data;
        end else begin
            n_out_code = r_s1_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_code <= n_out_code;
            r_out_bad  <= n_out_bad;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_out_code;
    assign o_bad_input  = r_out_bad;

endmodule

// ===== src/sjd_checker.sv =====
module sjd_checker
    import sjd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [CP_W-1:0]  o_code_point,
    input logic             o_bad_input
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_point) && $stable(o_bad_input))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_input |-> o_code_point == '0)
        else $error("bad-input result carries a code point");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind shift_jis_to_unicode_decoder_unit sjd_checker u_sjd_checker (.*);
